FILE: design/lzss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LZSS byte decompressor.
// No dependencies.
package lzss_pkg;

  localparam int DEF_WINDOW_DEPTH = 4096;
  localparam int DEF_MAX_MATCH    = 15;

  localparam int LEN_W  = 24;
  localparam int DIST_W = 12;

  localparam logic [7:0] FLAG_MSB       = 8'h80;
  localparam logic [3:0] LEN_MASK       = 4'hF;
  localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD_Q,
    ST_MOD_R,
    ST_READ,
    ST_COPY
  } state_t;

  typedef struct packed {
    logic done;
    logic phase1;
    logic flags_empty;
    logic flag_msb;
    logic mlen_zero;
    logic prod_lt;
    logic slot_free;
    logic cnt_one;
  } dp_status_t;

  typedef struct packed {
    logic cfg_we;
    logic load_flag;
    logic lit;
    logic low;
    logic match;
    logic skip;
    logic err;
    logic clr;
    logic mod_q;
    logic mod_r;
    logic rd;
    logic cp;
  } dp_cmd_t;

endpackage

FILE: design/lzss_byte_decompressor_core.sv
`timescale 1ns / 1ps
// LZSS byte decompressor top level: flag, literal and low-byte transactions are accepted
// in the idle state; a literal appears at the output in the cycle after acceptance. A match
// token is accepted, its distance is reduced (quotient, then remainder), and each copied byte
// takes a read and a write of the single-port history memory; input is held meanwhile.
// Reset (synchronous, rst_n low) clears parse state, out_length and the history fill count;
// never-written history entries read as zero, so no clearing pass is needed.
module lzss_byte_decompressor_core
  import lzss_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int MAX_MATCH    = DEF_MAX_MATCH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic             out_truncated,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_out_length
);

  dp_status_t sts;
  dp_cmd_t    cmd;

  lzss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lzss_dpath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MAX_MATCH    (MAX_MATCH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .cfg_out_length (cfg_out_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_truncated  (out_truncated)
  );

endmodule

FILE: design/lzss_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: decodes each input transaction and sequences match copies.
// Depends on lzss_pkg.
module lzss_ctrl
  import lzss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_ready,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  logic live;
  logic act_flag;
  logic act_lit;
  logic act_low;
  logic act_match;
  logic act_skip;

  assign live      = !sts.done;
  assign act_flag  = live && !sts.phase1 && sts.flags_empty;
  assign act_lit   = live && !sts.phase1 && !sts.flags_empty && sts.flag_msb;
  assign act_low   = live && !sts.phase1 && !sts.flags_empty && !sts.flag_msb;
  assign act_match = live && sts.phase1 && !sts.mlen_zero;
  assign act_skip  = live && sts.phase1 && sts.mlen_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = sts.slot_free;
        cfg_ready  = 1'b1;
        cmd.cfg_we = cfg_valid;
        if (in_valid && sts.slot_free) begin
          cmd.load_flag = act_flag;
          cmd.lit       = act_lit;
          cmd.low       = act_low;
          cmd.match     = act_match;
          cmd.skip      = act_skip;
          cmd.err       = in_last && sts.prod_lt && !act_lit && !act_match;
          cmd.clr       = in_last && !act_match;
          if (act_match) begin
            state_nxt = ST_MOD_Q;
          end
        end
      end
      ST_MOD_Q: begin
        cmd.mod_q = 1'b1;
        state_nxt = ST_MOD_R;
      end
      ST_MOD_R: begin
        cmd.mod_r = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_COPY;
      end
      ST_COPY: begin
        if (sts.slot_free) begin
          cmd.cp    = 1'b1;
          state_nxt = sts.cnt_one ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/lzss_dpath.sv
`timescale 1ns / 1ps
// Datapath: parse registers, history store with fill count, distance reduction, output register.
// Depends on lzss_pkg.
module lzss_dpath
  import lzss_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int MAX_MATCH    = DEF_MAX_MATCH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  output dp_status_t       sts,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  input  logic [LEN_W-1:0] cfg_out_length,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic             out_truncated
);

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int FW    = $clog2(WINDOW_DEPTH + 1);
  localparam int CW    = $clog2(MAX_MATCH + 1);
  localparam int SH    = DIST_W + AW;
  localparam int MW    = DIST_W + 2;
  localparam int PW    = DIST_W + MW;
  localparam int QW    = DIST_W + AW + 1;
  localparam int RECIP = (2 ** SH + WINDOW_DEPTH - 1) / WINDOW_DEPTH;

  localparam logic [MW-1:0] RECIP_C  = MW'(RECIP);
  localparam logic [AW:0]   WIN_C    = (AW + 1)'(WINDOW_DEPTH);
  localparam logic [AW-1:0] WIN_LAST = AW'(WINDOW_DEPTH - 1);
  localparam logic [CW-1:0] MAXM_C   = CW'(MAX_MATCH);

  logic [7:0] hist_mem [WINDOW_DEPTH];

  logic [LEN_W-1:0]  out_length_r;
  logic [LEN_W-1:0]  produced_r;
  logic [7:0]        flag_bits_r;
  logic [3:0]        flags_left_r;
  logic              phase_r;
  logic [7:0]        low_half_r;
  logic              chunk_done_r;
  logic [AW-1:0]     wr_addr_r;
  logic [FW-1:0]     fill_r;
  logic [DIST_W-1:0] dist_r;
  logic [DIST_W-1:0] q_r;
  logic [AW-1:0]     dmod_r;
  logic [CW-1:0]     count_r;
  logic              last_r;
  logic [7:0]        rd_q_r;
  logic              rd_ok_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r;
  logic              out_trunc_r;

  logic [LEN_W-1:0]  room;
  logic              room_one;
  logic [3:0]        len_raw;
  logic [CW-1:0]     len_c;
  logic [CW-1:0]     match_len;
  logic [PW-1:0]     recip_prod;
  logic [QW-1:0]     qw;
  logic [DIST_W-1:0] rem;
  logic [AW:0]       rd_wrap;
  logic [AW-1:0]     rd_addr;
  logic [7:0]        copy_byte;
  logic [7:0]        wr_data;
  logic              wr_en;
  logic              emit;
  logic              final_cp;
  logic              clr_any;
  logic              slot_free;

  assign room      = out_length_r - produced_r;
  assign room_one  = (room == LEN_W'(1));
  assign len_raw   = low_half_r[3:0] & LEN_MASK;
  assign len_c     = (int'(len_raw) > MAX_MATCH) ? MAXM_C : CW'(len_raw);
  assign match_len = (LEN_W'(len_c) > room) ? CW'(room) : len_c;

  assign recip_prod = PW'(dist_r) * PW'(RECIP_C);
  assign qw         = QW'(q_r) * QW'(WINDOW_DEPTH);
  assign rem        = dist_r - qw[DIST_W-1:0];

  assign rd_wrap = {1'b0, wr_addr_r} + WIN_C - {1'b0, dmod_r};
  assign rd_addr = (wr_addr_r >= dmod_r) ? (wr_addr_r - dmod_r) : rd_wrap[AW-1:0];

  assign copy_byte = rd_ok_r ? rd_q_r : 8'h00;
  assign wr_en     = cmd.lit | cmd.cp;
  assign wr_data   = cmd.lit ? in_byte : copy_byte;
  assign emit      = cmd.lit | cmd.cp | cmd.err;
  assign final_cp  = (count_r == CW'(1));
  assign clr_any   = cmd.clr | (cmd.cp & final_cp & last_r);
  assign slot_free = !out_valid_r || out_ready;

  assign sts.done        = chunk_done_r || (produced_r >= out_length_r);
  assign sts.phase1      = phase_r;
  assign sts.flags_empty = (flags_left_r == 4'd0);
  assign sts.flag_msb    = ((flag_bits_r & FLAG_MSB) != 8'h00);
  assign sts.mlen_zero   = (len_raw == 4'd0);
  assign sts.prod_lt     = (produced_r < out_length_r);
  assign sts.slot_free   = slot_free;
  assign sts.cnt_one     = final_cp;

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last      = out_last_r;
  assign out_truncated = out_trunc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_length_r <= '0;
      produced_r   <= '0;
      flag_bits_r  <= '0;
      flags_left_r <= '0;
      phase_r      <= 1'b0;
      low_half_r   <= '0;
      chunk_done_r <= 1'b0;
      wr_addr_r    <= '0;
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.cfg_we) begin
        out_length_r <= cfg_out_length;
      end
      if (cmd.load_flag) begin
        flag_bits_r  <= in_byte;
        flags_left_r <= FLAGS_PER_BYTE;
      end
      if (cmd.lit || cmd.match || cmd.skip) begin
        flag_bits_r  <= flag_bits_r << 1;
        flags_left_r <= flags_left_r - 4'd1;
      end
      if (cmd.low) begin
        low_half_r <= in_byte;
        phase_r    <= 1'b1;
      end
      if (cmd.match || cmd.skip) begin
        phase_r <= 1'b0;
      end
      if (wr_en) begin
        produced_r <= produced_r + LEN_W'(1);
        wr_addr_r  <= (wr_addr_r == WIN_LAST) ? '0 : wr_addr_r + AW'(1);
        if (fill_r == FW'(wr_addr_r)) begin
          fill_r <= fill_r + FW'(1);
        end
        if (room_one) begin
          chunk_done_r <= 1'b1;
        end
      end
      if (clr_any) begin
        produced_r   <= '0;
        flag_bits_r  <= '0;
        flags_left_r <= '0;
        phase_r      <= 1'b0;
        low_half_r   <= '0;
        chunk_done_r <= 1'b0;
        wr_addr_r    <= '0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      dist_r  <= {in_byte, low_half_r[7:4]};
      count_r <= match_len;
      last_r  <= in_last;
    end
    if (cmd.mod_q) begin
      q_r <= DIST_W'(recip_prod >> SH);
    end
    if (cmd.mod_r) begin
      dmod_r <= AW'(rem);
    end
    if (cmd.cp) begin
      count_r <= count_r - CW'(1);
    end
    if (emit) begin
      if (cmd.err) begin
        out_byte_r  <= 8'h00;
        out_last_r  <= 1'b1;
        out_trunc_r <= 1'b1;
      end else if (cmd.lit) begin
        out_byte_r  <= wr_data;
        out_last_r  <= in_last || room_one;
        out_trunc_r <= in_last && !room_one;
      end else begin
        out_byte_r  <= wr_data;
        out_last_r  <= final_cp && (room_one || last_r);
        out_trunc_r <= final_cp && last_r && !room_one;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_q_r  <= hist_mem[rd_addr];
      rd_ok_r <= (FW'(rd_addr) < fill_r);
    end
    if (wr_en) begin
      hist_mem[wr_addr_r] <= wr_data;
    end
  end

endmodule

FILE: design/lzss_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the LZSS decompressor, bound to the top level.
// Depends on lzss_byte_decompressor_core.
module lzss_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       out_truncated,
  input logic       cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last)
      && $stable(out_truncated))
    else $error("output transaction changed while stalled");

  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated |-> out_last)
    else $error("truncated result without out_last");

  a_in_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid || out_ready)
    else $error("input taken while output slot blocked");

  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> cfg_ready)
    else $error("input taken while not idle");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind lzss_byte_decompressor_core lzss_chk u_lzss_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_byte      (out_byte),
  .out_last      (out_last),
  .out_truncated (out_truncated),
  .cfg_ready     (cfg_ready)
);
